@@ rtl/gbm_pkg.sv @@
// Shared constants, types and codes of the gray box mean filter.
package gbm_pkg;

    // Window geometry
    localparam int RADIUS      = 13;
    localparam int SPAN        = 2 * RADIUS + 1;
    localparam int AREA        = SPAN * SPAN;
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;

    // Field and counter widths
    localparam int PIX_W       = 8;
    localparam int W_W         = 12;
    localparam int H_W         = 13;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int SLOT_W      = $clog2(SPAN);
    localparam int LS_AW       = SLOT_W + COL_W;
    localparam int LS_DEPTH    = SPAN * MAX_WIDTH;
    localparam int CS_W        = $clog2(SPAN * 255 + 1);
    localparam int WS_W        = $clog2(AREA * 255 + 1);
    localparam int DLY_W       = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
    localparam int PEND_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int CFG_IW      = 2;
    localparam int CFG_DW      = H_W;

    // Q16 luma coefficients
    localparam int GRAY_W      = 24;
    localparam int COEF_R      = 19661;
    localparam int COEF_G      = 38666;
    localparam int COEF_B      = 6554;

    // Divide by AREA as multiply by rounded-up reciprocal and shift
    localparam int DIV_SHIFT   = 28;
    localparam int DIV_MUL     = (2 ** DIV_SHIFT + AREA - 1) / AREA;
    localparam int DIV_MUL_W   = $clog2(DIV_MUL + 1);
    localparam int PROD_W      = WS_W + DIV_MUL_W;

    // Register reset values
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Output queue
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IW-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1
    } t_cfg_idx;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } t_action;

    // Control that travels with a transaction through the first stage
    typedef struct packed {
        logic pix;          // update column and window sums
        logic emit;         // transaction produces a result
        logic avg;          // result is the window mean
        logic last;         // result closes the frame
        logic first_row;    // column sums not yet written this frame
        logic sub_old;      // remove the line leaving the window
        logic col_zero;     // window restarts at the row start
        logic col_ge_span;  // drop the column leaving the window
        logic fwd_cs;       // column sum comes from the previous transaction
        logic fwd_pix;      // border pixel comes from the previous transaction
    } t_s1_ctl;

    typedef struct packed {
        logic [PIX_W-1:0] gray;
        logic             border;
        logic             last;
    } t_out;

endpackage

@@ rtl/gbm_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
module gbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write one entry, read two; a read at the written address returns old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/gray_box_mean_filter.sv @@
// Gray conversion and 27x27 box mean over a raster pixel stream.
// Throughput: one transaction per cycle if o_ready, set by the read-modify-write of
//   the column-sum and line memories (forwarding covers back-to-back same-column access).
// Latency: a result passes stages 1 and 2 into the output queue; a pixel's
//   own result follows 13 lines plus 13 pixels later in the stream, the tail on flushes.
// Reset: counters, pipeline and queue clear, width 640, height 480; no clearing pass,
//   line memory contents stay undefined and column sums are masked in the first row.
module gray_box_mean_filter
    import gbm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input pixel channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_action,
    input  logic [PIX_W-1:0]  i_blue,
    input  logic [PIX_W-1:0]  i_green,
    input  logic [PIX_W-1:0]  i_red,
    // Result channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic [PIX_W-1:0]  o_gray_out,
    output logic              o_from_border,
    output logic              o_frame_last,
    // Configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    // Clamp width to [1, MAX_WIDTH], return width minus one
    function automatic logic [COL_W-1:0] width_last(input logic [W_W-1:0] v);
        logic [W_W-1:0] w;
        w = v;
        if (w == '0) begin
            w = W_W'(1);
        end else if (w > W_W'(MAX_WIDTH)) begin
            w = W_W'(MAX_WIDTH);
        end
        return COL_W'(w - W_W'(1));
    endfunction

    // Clamp height to [1, MAX_HEIGHT], return height minus one
    function automatic logic [ROW_W-1:0] height_last(input logic [H_W-1:0] v);
        logic [H_W-1:0] h;
        h = v;
        if (h == '0) begin
            h = H_W'(1);
        end else if (h > H_W'(MAX_HEIGHT)) begin
            h = H_W'(MAX_HEIGHT);
        end
        return ROW_W'(h - H_W'(1));
    endfunction

    // Pixels between a pixel's arrival and its result: RADIUS*width + RADIUS
    function automatic logic [DLY_W-1:0] frame_delay(input logic [COL_W-1:0] wl);
        return DLY_W'(wl) * DLY_W'(RADIUS) + DLY_W'(2 * RADIUS);
    endfunction

    // Configuration
    logic [COL_W-1:0]  r_w_last,  n_w_last;
    logic [ROW_W-1:0]  r_h_last,  n_h_last;
    logic [DLY_W-1:0]  r_delay,   n_delay;

    // Frame position
    logic [COL_W-1:0]  r_in_col,  n_in_col;
    logic [ROW_W-1:0]  r_in_row,  n_in_row;
    logic [SLOT_W-1:0] r_in_slot, n_in_slot;
    logic              r_in_ge_span, n_in_ge_span;
    logic              r_frame_in, n_frame_in;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic [PEND_W-1:0] r_pending, n_pending;

    // Acceptance decode
    logic              in_acc;
    logic              cfg_wr;
    logic              is_pix;
    logic              do_emit;
    logic              em_border;
    logic              em_last;
    logic              restart;
    logic [GRAY_W-1:0] gray_sum;
    logic [LS_AW-1:0]  ls_raddr_b;

    // Stage 1
    logic              r_s1_v;
    t_s1_ctl           r_s1_ctl;
    logic [PIX_W-1:0]  r_s1_gray;
    logic [COL_W-1:0]  r_s1_col;
    logic [LS_AW-1:0]  r_s1_ls_addr;
    logic [CS_W-1:0]   r_s1_fwd_cs;
    logic [PIX_W-1:0]  r_s1_fwd_pix;
    logic [PIX_W-1:0]  ls_rd_a;
    logic [PIX_W-1:0]  ls_rd_b;
    logic [CS_W-1:0]   cs_rd_a;
    logic [CS_W-1:0]   cs_rd_b;
    logic [CS_W-1:0]   cs_base;
    logic [CS_W-1:0]   s1_cs;
    logic [WS_W-1:0]   ws_new;
    logic [PIX_W-1:0]  s1_pix_val;
    logic              s1_wr;
    logic [WS_W-1:0]   r_ws;

    // Stage 2
    logic              r_s2_v;
    logic              r_s2_avg;
    logic              r_s2_last;
    logic [PIX_W-1:0]  r_s2_pix;
    logic [PROD_W-1:0] s2_prod;
    t_out              s2_out;

    // Output queue
    t_out              r_fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_fifo_cnt;
    logic              fifo_push;
    logic              fifo_pop;
    logic [FIFO_CW-1:0] in_flight;

    // Handshakes: hold input while queued plus in-flight results could fill the queue
    assign in_flight = r_fifo_cnt + FIFO_CW'(r_s1_v && r_s1_ctl.emit) + FIFO_CW'(r_s2_v);
    assign o_ready   = in_flight < FIFO_CW'(FIFO_DEPTH);
    assign o_cfg_ready = 1'b1;
    assign in_acc    = i_valid && o_ready;
    assign cfg_wr    = i_cfg_valid && o_cfg_ready;

    // Classify the transaction: pixel, post-frame item with result, or ignored early flush
    assign is_pix   = in_acc && (i_action == ACT_PIXEL) && !r_frame_in;
    assign do_emit  = in_acc && (r_frame_in || (is_pix && (r_pending >= PEND_W'(r_delay))));
    assign em_border = (r_out_row <= ROW_W'(RADIUS))
                    || (({1'b0, r_out_row} + H_W'(RADIUS)) > H_W'(r_h_last))
                    || (r_out_col <= COL_W'(RADIUS))
                    || (({1'b0, r_out_col} + W_W'(RADIUS)) > W_W'(r_w_last));
    assign em_last  = (r_out_row == r_h_last) && (r_out_col == r_w_last);
    assign restart  = (do_emit && em_last)
                   || (cfg_wr && (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT));

    // Q16 luma, truncated
    assign gray_sum = GRAY_W'(i_red) * GRAY_W'(COEF_R)
                    + GRAY_W'(i_green) * GRAY_W'(COEF_G)
                    + GRAY_W'(i_blue) * GRAY_W'(COEF_B);

    assign ls_raddr_b = {r_out_slot, r_out_col};

    // Advance counters, restart on frame end or width or height register write
    always_comb begin
        n_w_last     = r_w_last;
        n_h_last     = r_h_last;
        n_delay      = r_delay;
        n_in_col     = r_in_col;
        n_in_row     = r_in_row;
        n_in_slot    = r_in_slot;
        n_in_ge_span = r_in_ge_span;
        n_frame_in   = r_frame_in;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;
        n_out_slot   = r_out_slot;
        n_pending    = r_pending;

        if (is_pix) begin
            if (r_in_col == r_w_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
                if (r_in_slot == SLOT_W'(SPAN - 1)) begin
                    n_in_slot    = '0;
                    n_in_ge_span = 1'b1;
                end else begin
                    n_in_slot = r_in_slot + SLOT_W'(1);
                end
                if (r_in_row == r_h_last) begin
                    n_frame_in = 1'b1;
                end
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
        end

        if (is_pix && !do_emit) begin
            n_pending = r_pending + PEND_W'(1);
        end else if (do_emit && !is_pix) begin
            n_pending = r_pending - PEND_W'(1);
        end

        if (do_emit) begin
            if (r_out_col == r_w_last) begin
                n_out_col = '0;
                n_out_row = r_out_row + ROW_W'(1);
                if (r_out_slot == SLOT_W'(SPAN - 1)) begin
                    n_out_slot = '0;
                end else begin
                    n_out_slot = r_out_slot + SLOT_W'(1);
                end
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end

        if (cfg_wr) begin
            case (i_cfg_index)
                CFG_WIDTH: begin
                    n_w_last = width_last(i_cfg_data[W_W-1:0]);
                    n_delay  = frame_delay(width_last(i_cfg_data[W_W-1:0]));
                end
                CFG_HEIGHT: begin
                    n_h_last = height_last(i_cfg_data);
                end
                default: begin
                end
            endcase
        end

        if (restart) begin
            n_in_col     = '0;
            n_in_row     = '0;
            n_in_slot    = '0;
            n_in_ge_span = 1'b0;
            n_frame_in   = 1'b0;
            n_out_col    = '0;
            n_out_row    = '0;
            n_out_slot   = '0;
            n_pending    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last     <= COL_W'(RESET_WIDTH - 1);
            r_h_last     <= ROW_W'(RESET_HEIGHT - 1);
            r_delay      <= frame_delay(COL_W'(RESET_WIDTH - 1));
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_in_slot    <= '0;
            r_in_ge_span <= 1'b0;
            r_frame_in   <= 1'b0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_out_slot   <= '0;
            r_pending    <= '0;
        end else begin
            r_w_last     <= n_w_last;
            r_h_last     <= n_h_last;
            r_delay      <= n_delay;
            r_in_col     <= n_in_col;
            r_in_row     <= n_in_row;
            r_in_slot    <= n_in_slot;
            r_in_ge_span <= n_in_ge_span;
            r_frame_in   <= n_frame_in;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
            r_out_slot   <= n_out_slot;
            r_pending    <= n_pending;
        end
    end

    // Line store: port A reads the line leaving the column, port B the border pixel
    gbm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LS_DEPTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (s1_wr),
        .i_waddr   (r_s1_ls_addr),
        .i_wdata   (r_s1_gray),
        .i_raddr_a ({r_in_slot, r_in_col}),
        .o_rdata_a (ls_rd_a),
        .i_raddr_b (ls_raddr_b),
        .o_rdata_b (ls_rd_b)
    );

    // Column sums: port A the current column, port B the column leaving the window
    gbm_ram #(
        .WIDTH (CS_W),
        .DEPTH (MAX_WIDTH)
    ) u_colsum_ram (
        .i_clk     (i_clk),
        .i_we      (s1_wr),
        .i_waddr   (r_s1_col),
        .i_wdata   (s1_cs),
        .i_raddr_a (r_in_col),
        .o_rdata_a (cs_rd_a),
        .i_raddr_b (r_in_col - COL_W'(SPAN)),
        .o_rdata_b (cs_rd_b)
    );

    // Stage 1 control: valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= is_pix || do_emit;
        end
    end

    // Stage 1 payload, with forwarding from the transaction now in stage 1
    always_ff @(posedge i_clk) begin
        r_s1_ctl.pix         <= is_pix;
        r_s1_ctl.emit        <= do_emit;
        r_s1_ctl.avg         <= !em_border && !r_frame_in;
        r_s1_ctl.last        <= em_last;
        r_s1_ctl.first_row   <= (r_in_row == '0);
        r_s1_ctl.sub_old     <= r_in_ge_span;
        r_s1_ctl.col_zero    <= (r_in_col == '0);
        r_s1_ctl.col_ge_span <= (r_in_col >= COL_W'(SPAN));
        r_s1_ctl.fwd_cs      <= s1_wr && (r_s1_col == r_in_col);
        r_s1_ctl.fwd_pix     <= s1_wr && (r_s1_ls_addr == ls_raddr_b);
        r_s1_gray            <= gray_sum[GRAY_W-1 -: PIX_W];
        r_s1_col             <= r_in_col;
        r_s1_ls_addr         <= {r_in_slot, r_in_col};
        r_s1_fwd_cs          <= s1_cs;
        r_s1_fwd_pix         <= r_s1_gray;
    end

    // Update the column sum and the running window sum
    assign s1_wr   = r_s1_v && r_s1_ctl.pix;
    assign cs_base = r_s1_ctl.first_row ? '0 : (r_s1_ctl.fwd_cs ? r_s1_fwd_cs : cs_rd_a);
    assign s1_cs   = cs_base - (r_s1_ctl.sub_old ? CS_W'(ls_rd_a) : '0) + CS_W'(r_s1_gray);
    assign ws_new  = (r_s1_ctl.col_zero ? '0 : r_ws) + WS_W'(s1_cs)
                   - (r_s1_ctl.col_ge_span ? WS_W'(cs_rd_b) : '0);
    assign s1_pix_val = r_s1_ctl.fwd_pix ? r_s1_fwd_pix : ls_rd_b;

    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            r_ws <= ws_new;
        end
    end

    // Stage 2: hold the result pending the divide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v && r_s1_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_avg  <= r_s1_ctl.avg;
        r_s2_last <= r_s1_ctl.last;
        r_s2_pix  <= s1_pix_val;
    end

    // Window mean: r_ws still holds this transaction's sum here
    assign s2_prod       = PROD_W'(r_ws) * PROD_W'(DIV_MUL);
    assign s2_out.gray   = r_s2_avg ? s2_prod[DIV_SHIFT +: PIX_W] : r_s2_pix;
    assign s2_out.border = !r_s2_avg;
    assign s2_out.last   = r_s2_last;

    // Output queue
    assign fifo_push = r_s2_v;
    assign fifo_pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (fifo_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (fifo_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (fifo_push && !fifo_pop) begin
                r_fifo_cnt <= r_fifo_cnt + FIFO_CW'(1);
            end else if (fifo_pop && !fifo_push) begin
                r_fifo_cnt <= r_fifo_cnt - FIFO_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fifo_push) begin
            r_fifo_mem[r_wr_ptr] <= s2_out;
        end
    end

    assign o_valid       = (r_fifo_cnt != '0);
    assign o_gray_out    = r_fifo_mem[r_rd_ptr].gray;
    assign o_from_border = r_fifo_mem[r_rd_ptr].border;
    assign o_frame_last  = r_fifo_mem[r_rd_ptr].last;

    // Queue never takes a result it has no room for
    a_fifo_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fifo_push && !fifo_pop) |-> (r_fifo_cnt < FIFO_CW'(FIFO_DEPTH)))
        else $error("output queue overflow");

    // Pixel path never runs ahead of the frame delay
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_frame_in |-> (r_pending <= PEND_W'(r_delay)))
        else $error("pending count exceeds frame delay");

    // A frame is complete only at a row boundary
    a_frame_in_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_in |-> (r_in_col == '0))
        else $error("frame complete with partial row");

    // The last result of a frame is always a border pixel
    a_last_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && r_s2_last) |-> !r_s2_avg)
        else $error("averaged pixel marked frame last");

endmodule

@@ sim/tb_gray_box_mean_filter.sv @@
// Testbench for gray_box_mean_filter: random raster frames checked against a local box-mean predictor.
`timescale 1ns / 1ps

module tb_gray_box_mean_filter
    import gbm_pkg::*;
;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 300000;

    // Register indexes with no register behind them
    localparam logic [CFG_IW-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IW-1:0] REG_SPARE_HI = 2'd3;

    typedef struct {
        t_action          action;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_stream_item;

    typedef enum int {SHADE_NOISE, SHADE_WHITE, SHADE_BLACK, SHADE_BRIGHT} t_shade;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} t_rx_mode;

    // DUT ports
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic              i_action = ACT_PIXEL;
    logic [PIX_W-1:0]  i_blue = '0;
    logic [PIX_W-1:0]  i_green = '0;
    logic [PIX_W-1:0]  i_red = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [PIX_W-1:0]  o_gray_out;
    logic              o_from_border;
    logic              o_frame_last;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    // Predictor state
    int unsigned       width_reg;
    int unsigned       height_reg;
    logic [PIX_W-1:0]  line_copy [LS_DEPTH];
    int unsigned       col_total [MAX_WIDTH];
    int unsigned       win_total;
    int unsigned       row_in;
    int unsigned       col_in;
    int unsigned       next_out;

    t_stream_item      pixel_backlog[$];
    t_out              expected_pixels[$];
    int                mismatch_count = 0;
    int                cycle_count = 0;

    // Driver, receiver and monitor working variables
    t_stream_item      next_item;
    t_out              drv_res;
    t_out              want;
    int unsigned       burst_left = 0;
    int unsigned       gap_left = 0;
    int unsigned       hold_left = 0;
    int unsigned       mode_left = 0;
    t_rx_mode          rx_mode = RX_OPEN;
    logic              hold_arm = 1'b0;
    logic              hold_done = 1'b0;

    gray_box_mean_filter dut (.*);

    // Generate clock
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_frame();
        foreach (col_total[i]) col_total[i] = 0;
        win_total = 0;
        row_in    = 0;
        col_in    = 0;
        next_out  = 0;
    endfunction

    // Produce the next raster output; averaging only on the pixel path
    function automatic void take_output(input int unsigned w, h, input bit may_avg,
                                        output t_out res);
        int unsigned ro;
        int unsigned co;
        bit          border;
        ro = next_out / w;
        co = next_out % w;
        border = ro <= RADIUS || ro + RADIUS >= h || co <= RADIUS || co + RADIUS >= w;
        if (border || !may_avg) begin
            res.gray   = line_copy[(ro % SPAN) * MAX_WIDTH + co];
            res.border = 1'b1;
        end else begin
            res.gray   = PIX_W'(win_total / AREA);
            res.border = 1'b0;
        end
        res.last = (next_out + 1 == w * h);
        next_out++;
        if (res.last) restart_frame();
    endfunction

    // Advance the filter by one transaction; return 1 when it yields a pixel
    function automatic bit predict_filter_output(input t_action act,
                                                 input logic [PIX_W-1:0] b, g, r,
                                                 output t_out res);
        int unsigned w;
        int unsigned h;
        int unsigned lag;
        int unsigned gray;
        int unsigned slot;
        int unsigned cs;
        int unsigned arrived;
        bit          frame_in;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        lag = RADIUS * w + RADIUS;
        frame_in = (row_in >= h);
        res = '0;
        if (act == ACT_PIXEL && !frame_in) begin
            gray = (COEF_R * int'(r) + COEF_G * int'(g) + COEF_B * int'(b)) >> 16;
            slot = (row_in % SPAN) * MAX_WIDTH + col_in;
            // Swap the oldest line out of the column sum
            cs = col_total[col_in];
            if (row_in >= SPAN) cs -= line_copy[slot];
            cs += gray;
            col_total[col_in] = cs;
            line_copy[slot] = PIX_W'(gray);
            // Slide the horizontal window
            if (col_in == 0) begin
                win_total = cs;
            end else begin
                win_total += cs;
                if (col_in >= SPAN) win_total -= col_total[col_in - SPAN];
            end
            col_in++;
            if (col_in >= w) begin
                col_in = 0;
                row_in++;
            end
            arrived = row_in * w + col_in;
            if (arrived > lag + next_out && next_out < w * h) begin
                take_output(w, h, 1'b1, res);
                return 1'b1;
            end
            return 1'b0;
        end
        // Early flush is dropped; anything after the frame drains the tail
        if (!frame_in) return 1'b0;
        take_output(w, h, 1'b0, res);
        return 1'b1;
    endfunction

    function automatic void push_item(input t_action act, input logic [PIX_W-1:0] b, g, r);
        t_stream_item item;
        item.action = act;
        item.blue   = b;
        item.green  = g;
        item.red    = r;
        pixel_backlog.push_back(item);
    endfunction

    function automatic logic [PIX_W-1:0] shade_level(input t_shade s);
        case (s)
            SHADE_WHITE:  return '1;
            SHADE_BLACK:  return '0;
            SHADE_BRIGHT: return PIX_W'($urandom_range(240, 255));
            default:      return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Queue pixels [first, stop) of a w x h frame, optionally followed by its drain tail
    task automatic queue_frame(input int unsigned w, h, first, stop, input bit with_tail);
        t_shade      shade;
        int unsigned pick;
        int unsigned lag;
        int unsigned tail;
        shade = SHADE_NOISE;
        for (int unsigned k = first; k < stop; k++) begin
            if (k % w == 0 || k == first) begin
                pick = $urandom_range(0, 9);
                shade = (pick <= 4) ? SHADE_NOISE : (pick <= 6) ? SHADE_WHITE :
                        (pick == 7) ? SHADE_BLACK : SHADE_BRIGHT;
            end
            // Sprinkle premature flushes, which the block must ignore
            if ($urandom_range(0, 31) == 0)
                push_item(ACT_FLUSH, PIX_W'($urandom_range(0, 255)),
                          PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)));
            push_item(ACT_PIXEL, shade_level(shade), shade_level(shade), shade_level(shade));
        end
        if (with_tail) begin
            lag = RADIUS * w + RADIUS;
            tail = (lag < w * h) ? lag : w * h;
            repeat (tail) begin
                push_item(($urandom_range(0, 3) == 0) ? ACT_PIXEL : ACT_FLUSH,
                          PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                          PIX_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // Wait until every transaction is taken and every result has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pixel_backlog.size() != 0 || i_valid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH) begin
            width_reg = val[W_W-1:0];
            restart_frame();
        end else if (idx == CFG_HEIGHT) begin
            height_reg = val[H_W-1:0];
            restart_frame();
        end
    endtask

    // Drive pixel transactions in bursts; predict each one as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            i_action <= ACT_PIXEL;
            i_blue   <= '0;
            i_green  <= '0;
            i_red    <= '0;
        end else begin
            if (i_valid && o_ready) begin
                if (predict_filter_output(t_action'(i_action), i_blue, i_green, i_red,
                                          drv_res))
                    expected_pixels.push_back(drv_res);
            end
            if (!i_valid || o_ready) begin
                if (gap_left != 0 || pixel_backlog.size() == 0) begin
                    i_valid <= 1'b0;
                    if (gap_left != 0) gap_left <= gap_left - 1;
                end else begin
                    next_item = pixel_backlog.pop_front();
                    i_valid  <= 1'b1;
                    i_action <= next_item.action;
                    i_blue   <= next_item.blue;
                    i_green  <= next_item.green;
                    i_red    <= next_item.red;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // Stall the result channel; hold off once for a long stretch when armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (hold_arm && !hold_done && o_valid) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            i_ready   <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= t_rx_mode'($urandom_range(0, 2));
                mode_left <= $urandom_range(50, 300);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_OPEN: i_ready <= 1'b1;
                RX_COIN: i_ready <= ($urandom_range(0, 1) == 1);
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Compare each taken result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected result: gray_out %0d from_border %0d frame_last %0d",
                       o_gray_out, o_from_border, o_frame_last);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_gray_out !== want.gray) begin
                    $error("gray_out: expected %0d, got %0d", want.gray, o_gray_out);
                    mismatch_count++;
                end
                if (o_from_border !== want.border) begin
                    $error("from_border: expected %0d, got %0d", want.border, o_from_border);
                    mismatch_count++;
                end
                if (o_frame_last !== want.last) begin
                    $error("frame_last: expected %0d, got %0d", want.last, o_frame_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("gray_box_mean_filter test failed");
            $finish;
        end
    end

    initial begin
        int unsigned w;
        int unsigned h;
        width_reg  = RESET_WIDTH;
        height_reg = RESET_HEIGHT;
        restart_frame();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Channel extremes at the reset size; the flush comes too early to count
        push_item(ACT_PIXEL, 8'd0, 8'd0, 8'd0);
        push_item(ACT_PIXEL, 8'd255, 8'd255, 8'd255);
        push_item(ACT_PIXEL, 8'd255, 8'd0, 8'd0);
        push_item(ACT_PIXEL, 8'd0, 8'd255, 8'd0);
        push_item(ACT_PIXEL, 8'd0, 8'd0, 8'd255);
        push_item(ACT_FLUSH, 8'd255, 8'd255, 8'd255);
        wait_drained();

        // Zero sizes saturate to a single-pixel frame; a pixel past the frame drains it
        write_reg(CFG_WIDTH, '0);
        write_reg(CFG_HEIGHT, '0);
        push_item(ACT_PIXEL, 8'd1, 8'd128, 8'd255);
        push_item(ACT_PIXEL, 8'd0, 8'd0, 8'd0);
        push_item(ACT_FLUSH, 8'd17, 8'd34, 8'd51);
        push_item(ACT_PIXEL, 8'd37, 8'd201, 8'd90);
        push_item(ACT_FLUSH, 8'd0, 8'd0, 8'd0);
        wait_drained();

        // Small frame split by writes to unused indexes, which must not restart it
        write_reg(CFG_WIDTH, 13'h1005);
        write_reg(CFG_HEIGHT, 13'd3);
        queue_frame(5, 3, 0, 4, 1'b0);
        push_item(ACT_FLUSH, 8'd0, 8'd0, 8'd0);
        wait_drained();
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '0);
        queue_frame(5, 3, 4, 15, 1'b1);
        wait_drained();

        // Oversized registers saturate; partial frames only
        write_reg(CFG_WIDTH, 13'h0FFF);
        write_reg(CFG_HEIGHT, 13'h1FFF);
        queue_frame(MAX_WIDTH, MAX_HEIGHT, 0, 60, 1'b0);
        wait_drained();
        write_reg(CFG_WIDTH, 13'd2048);
        write_reg(CFG_HEIGHT, 13'd28);
        queue_frame(2048, 28, 0, 60, 1'b0);
        wait_drained();

        // Narrowest averaging width, tallest frame; cut short by the next write
        write_reg(CFG_WIDTH, 13'h101C);
        write_reg(CFG_HEIGHT, 13'd4096);
        queue_frame(28, 4096, 0, 60, 1'b0);
        wait_drained();

        // Full frame with an averaged interior; receiver holds off while pixels keep coming
        w = $urandom_range(28, 32);
        h = $urandom_range(29, 30);
        write_reg(CFG_HEIGHT, CFG_DW'(h));
        write_reg(CFG_WIDTH, CFG_DW'(w));
        hold_arm <= 1'b1;
        queue_frame(w, h, 0, w * h, 1'b1);
        wait_drained();

        // Single-column frame and a frame just too small to average
        write_reg(CFG_WIDTH, 13'd1);
        write_reg(CFG_HEIGHT, 13'd40);
        queue_frame(1, 40, 0, 40, 1'b1);
        wait_drained();
        write_reg(CFG_WIDTH, 13'd27);
        write_reg(CFG_HEIGHT, 13'd2);
        queue_frame(27, 2, 0, 54, 1'b1);
        wait_drained();

        // Random small frames, registers written in either order
        repeat (3) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_WIDTH, CFG_DW'(w));
                write_reg(CFG_HEIGHT, CFG_DW'(h));
            end else begin
                write_reg(CFG_HEIGHT, CFG_DW'(h));
                write_reg(CFG_WIDTH, CFG_DW'(w));
            end
            queue_frame(w, h, 0, w * h, 1'b1);
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("gray_box_mean_filter test passed");
        end else begin
            $display("gray_box_mean_filter test failed");
        end
        $finish;
    end

endmodule
